// File: rtl/rbs_pkg.sv
// shared types, constants and float helpers for the ray/box slab test
package rbs_pkg;

	localparam int AXES      = 3;
	localparam int FADD_LAT  = 3;
	localparam int FMUL_LAT  = 4;
	localparam int DIV_STEPS = 28;
	localparam int RECIP_LAT = DIV_STEPS + 2;
	localparam int SUB_DLY   = RECIP_LAT - FADD_LAT;
	localparam int MERGE_LAT = 2;
	localparam int PIPE_LAT  = RECIP_LAT + FMUL_LAT + MERGE_LAT;

	localparam logic [31:0] F_POS_INF = 32'h7F80_0000;
	localparam logic [31:0] F_NEG_INF = 32'hFF80_0000;
	localparam logic [31:0] F_QNAN    = 32'h7FC0_0000;

	typedef struct packed {
		logic [31:0] origin_x;
		logic [31:0] origin_y;
		logic [31:0] origin_z;
		logic [31:0] dir_x;
		logic [31:0] dir_y;
		logic [31:0] dir_z;
		logic [31:0] box_min_x;
		logic [31:0] box_min_y;
		logic [31:0] box_min_z;
		logic [31:0] box_max_x;
		logic [31:0] box_max_y;
		logic [31:0] box_max_z;
	} req_t;

	typedef struct packed {
		logic        hit;
		logic [31:0] t_enter;
		logic [31:0] t_exit;
	} rsp_t;

	function automatic logic is_nan(input logic [31:0] v);
		return (v[30:23] == 8'hFF) && (v[22:0] != 23'd0);
	endfunction

	function automatic logic is_inf(input logic [31:0] v);
		return (v[30:23] == 8'hFF) && (v[22:0] == 23'd0);
	endfunction

	function automatic logic is_zero(input logic [31:0] v);
		return v[30:0] == 31'd0;
	endfunction

	// leading zero count, 48 when the word is zero
	function automatic logic [5:0] lzc48(input logic [47:0] v);
		logic [5:0] n;
		logic       found;
		n = 6'd48;
		found = 1'b0;
		for (int i = 47; i >= 0; i--) begin
			if (!found && v[i]) begin
				n = 6'(47 - i);
				found = 1'b1;
			end
		end
		return n;
	endfunction

	// mant has its leading one at bit 26 (or is short of it at exponent one),
	// bits 2..0 are guard, round and sticky; round to nearest even
	function automatic logic [31:0] round_pack(input logic sign,
			input logic signed [9:0] exp, input logic [26:0] mant);
		logic [9:0]        sh;
		logic [26:0]       m;
		logic [26:0]       part;
		logic [26:0]       back;
		logic signed [9:0] e;
		logic [23:0]       keep;
		logic              inc;
		logic [7:0]        ef;
		logic [30:0]       body;
		logic [31:0]       res;
		part = '0;
		back = '0;
		if (exp < 10'sd1) begin
			sh = 10'(10'sd1 - exp);
			if (sh >= 10'd27) begin
				m = {26'd0, |mant};
			end else begin
				part = mant >> sh[4:0];
				back = part << sh[4:0];
				m = part | {26'd0, back != mant};
			end
			e = 10'sd1;
		end else begin
			sh = '0;
			m = mant;
			e = exp;
		end
		keep = m[26:3];
		inc = m[2] & (m[1] | m[0] | keep[0]);
		ef = keep[23] ? e[7:0] : 8'd0;
		body = {ef, keep[22:0]} + 31'(inc);
		if (e >= 10'sd255) begin
			res = {sign, F_POS_INF[30:0]};
		end else begin
			res = {sign, body};
		end
		return res;
	endfunction

	// ordered less-than, false when either side is nan, zeros compare equal
	function automatic logic f_lt(input logic [31:0] a, input logic [31:0] b);
		logic r;
		if (is_nan(a) || is_nan(b)) begin
			r = 1'b0;
		end else if (is_zero(a) && is_zero(b)) begin
			r = 1'b0;
		end else begin
			case ({a[31], b[31]})
				2'b10:   r = 1'b1;
				2'b01:   r = 1'b0;
				2'b00:   r = a[30:0] < b[30:0];
				default: r = a[30:0] > b[30:0];
			endcase
		end
		return r;
	endfunction

endpackage

// File: rtl/ray_box_slab_test.sv
// top level of the ray versus axis-aligned box slab test
// usage:
// - request channel (req_valid, req_stall, req) carries a ray origin, a ray
//   direction and the two box corners as single-precision words
// - response channel (rsp_valid, rsp_stall, rsp) returns hit, t_enter and
//   t_exit; both distances are zero on a miss
// - a transaction moves on a rising edge with valid high and stall low
// - one axis per lane; each lane has a 28-step pipelined reciprocal,
//   two subtractors and two multipliers, and the merge block folds the lanes
// - throughput is one transaction per cycle while req_stall is low, set
//   by the fully pipelined reciprocal
// - the block keeps no state between transactions
// - reset empties the pipeline, the output register and the skid register;
//   req_stall is low right after reset
// - when rsp_stall holds a waiting response, the next finished result goes
//   into a skid register, and only then does the pipeline freeze and
//   req_stall rise; req_stall comes straight from that register
module ray_box_slab_test (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          req_valid,
	output logic          req_stall,
	input  rbs_pkg::req_t req,
	output logic          rsp_valid,
	input  logic          rsp_stall,
	output rbs_pkg::rsp_t rsp
);

	localparam int AXES = rbs_pkg::AXES;
	localparam int LAT  = rbs_pkg::PIPE_LAT;

	logic en;
	logic accept;
	logic out_free;
	logic fin;

	// valid bit for every pipeline stage
	logic [LAT-1:0] vld_q;

	logic [31:0] org  [0:AXES-1];
	logic [31:0] dir  [0:AXES-1];
	logic [31:0] bmin [0:AXES-1];
	logic [31:0] bmax [0:AXES-1];
	logic [31:0] t0   [0:AXES-1];
	logic [31:0] t1   [0:AXES-1];

	logic [31:0]   near, far;
	rbs_pkg::rsp_t res;

	logic          rsp_valid_q, skid_valid_q;
	rbs_pkg::rsp_t rsp_q, skid_q;

	// the pipeline moves whenever the skid register is empty
	assign en        = ~skid_valid_q;
	assign req_stall = skid_valid_q;
	assign accept    = req_valid & ~skid_valid_q;
	assign fin       = vld_q[LAT-1];
	assign out_free  = ~rsp_valid_q | ~rsp_stall;

	always_comb begin
		org[0]  = req.origin_x;
		org[1]  = req.origin_y;
		org[2]  = req.origin_z;
		dir[0]  = req.dir_x;
		dir[1]  = req.dir_y;
		dir[2]  = req.dir_z;
		bmin[0] = req.box_min_x;
		bmin[1] = req.box_min_y;
		bmin[2] = req.box_min_z;
		bmax[0] = req.box_max_x;
		bmax[1] = req.box_max_y;
		bmax[2] = req.box_max_z;
	end

	for (genvar a = 0; a < AXES; a++) begin : g_lane
		rbs_lane u_lane (
			.clk     (clk),
			.en      (en),
			.origin  (org[a]),
			.dir     (dir[a]),
			.box_min (bmin[a]),
			.box_max (bmax[a]),
			.t0      (t0[a]),
			.t1      (t1[a])
		);
	end

	rbs_merge u_merge (
		.clk  (clk),
		.en   (en),
		.t0   (t0),
		.t1   (t1),
		.near (near),
		.far  (far)
	);

	// empty interval is a miss, reported with zero distances
	always_comb begin
		if (rbs_pkg::f_lt(far, near)) begin
			res = '0;
		end else begin
			res.hit     = 1'b1;
			res.t_enter = near;
			res.t_exit  = far;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (en) begin
			vld_q <= {vld_q[LAT-2:0], accept};
		end
	end

	// output and skid control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (skid_valid_q) begin
			if (out_free) begin
				skid_valid_q <= 1'b0;
				rsp_valid_q  <= 1'b1;
			end
		end else if (fin) begin
			if (out_free) begin
				rsp_valid_q <= 1'b1;
			end else begin
				skid_valid_q <= 1'b1;
			end
		end else if (out_free) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (skid_valid_q) begin
			if (out_free) begin
				rsp_q <= skid_q;
			end
		end else if (fin) begin
			if (out_free) begin
				rsp_q <= res;
			end else begin
				skid_q <= res;
			end
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule

// File: rtl/rbs_fsub.sv
// three-stage single-precision subtractor, res = a - b
module rbs_fsub (
	input  logic        clk,
	input  logic        en,
	input  logic [31:0] a,
	input  logic [31:0] b,
	output logic [31:0] res
);

	logic [31:0] bn, big, sml, part;
	logic        a_big;
	logic [7:0]  e_big, e_sml, diff;
	logic [26:0] m_big, m_sml, m_al;
	logic [27:0] sum;
	logic        nan, inf, inf_sign, zsign;

	logic        sign_s1, nan_s1, inf_s1, inf_sign_s1, zsign_s1;
	logic [7:0]  exp_s1;
	logic [27:0] sum_s1;

	logic [5:0]        lz;
	logic [7:0]        lim, sh;
	logic [26:0]       mant_n;
	logic signed [9:0] exp_n;

	logic              sign_s2, nan_s2, inf_s2, inf_sign_s2, zsign_s2, zero_s2;
	logic signed [9:0] exp_s2;
	logic [26:0]       mant_s2;

	logic [31:0] res_s3;

	// align and add
	always_comb begin
		bn = {~b[31], b[30:0]};
		a_big = a[30:0] >= bn[30:0];
		big = a_big ? a : bn;
		sml = a_big ? bn : a;
		e_big = (big[30:23] == 8'd0) ? 8'd1 : big[30:23];
		e_sml = (sml[30:23] == 8'd0) ? 8'd1 : sml[30:23];
		diff = e_big - e_sml;
		m_big = {big[30:23] != 8'd0, big[22:0], 3'b000};
		m_sml = {sml[30:23] != 8'd0, sml[22:0], 3'b000};
		part = '0;
		if (diff >= 8'd27) begin
			m_al = {26'd0, |m_sml};
		end else begin
			m_al = m_sml >> diff[4:0];
			part = {5'd0, m_al} << diff[4:0];
			m_al = m_al | {26'd0, part[26:0] != m_sml};
		end
		if (big[31] != sml[31]) begin
			sum = {1'b0, m_big} - {1'b0, m_al};
		end else begin
			sum = {1'b0, m_big} + {1'b0, m_al};
		end
		nan = rbs_pkg::is_nan(a) | rbs_pkg::is_nan(bn)
			| (rbs_pkg::is_inf(a) & rbs_pkg::is_inf(bn) & (a[31] != bn[31]));
		inf = rbs_pkg::is_inf(a) | rbs_pkg::is_inf(bn);
		inf_sign = rbs_pkg::is_inf(a) ? a[31] : bn[31];
		zsign = a[31] & bn[31];
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sign_s1     <= big[31];
			exp_s1      <= e_big;
			sum_s1      <= sum;
			nan_s1      <= nan;
			inf_s1      <= inf;
			inf_sign_s1 <= inf_sign;
			zsign_s1    <= zsign;
		end
	end

	// normalize, never below exponent one
	always_comb begin
		lz = rbs_pkg::lzc48({sum_s1[26:0], 21'd0});
		lim = exp_s1 - 8'd1;
		sh = ({2'b00, lz} > lim) ? lim : {2'b00, lz};
		if (sum_s1[27]) begin
			mant_n = {sum_s1[27:2], sum_s1[1] | sum_s1[0]};
			exp_n = 10'({2'b00, exp_s1}) + 10'sd1;
		end else begin
			mant_n = sum_s1[26:0] << sh;
			exp_n = 10'({2'b00, exp_s1 - sh});
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sign_s2     <= sign_s1;
			exp_s2      <= exp_n;
			mant_s2     <= mant_n;
			zero_s2     <= sum_s1 == 28'd0;
			nan_s2      <= nan_s1;
			inf_s2      <= inf_s1;
			inf_sign_s2 <= inf_sign_s1;
			zsign_s2    <= zsign_s1;
		end
	end

	// round and pick specials
	always_ff @(posedge clk) begin
		if (en) begin
			if (nan_s2) begin
				res_s3 <= rbs_pkg::F_QNAN;
			end else if (inf_s2) begin
				res_s3 <= {inf_sign_s2, rbs_pkg::F_POS_INF[30:0]};
			end else if (zero_s2) begin
				res_s3 <= {zsign_s2, 31'd0};
			end else begin
				res_s3 <= rbs_pkg::round_pack(sign_s2, exp_s2, mant_s2);
			end
		end
	end

	assign res = res_s3;

endmodule

// File: rtl/rbs_fmul.sv
// four-stage single-precision multiplier
module rbs_fmul (
	input  logic        clk,
	input  logic        en,
	input  logic [31:0] a,
	input  logic [31:0] b,
	output logic [31:0] res
);

	logic [7:0]        ea, eb;
	logic [23:0]       ma0, mb0;
	logic [5:0]        lza, lzb;

	logic [23:0]       ma_s1, mb_s1;
	logic signed [9:0] na_s1, nb_s1;
	logic              sign_s1, nan_s1, inf_s1, zero_s1;

	logic [47:0]       prod_s2;
	logic signed [9:0] exp_s2;
	logic              sign_s2, nan_s2, inf_s2, zero_s2;

	logic [26:0]       mant_s3;
	logic signed [9:0] exp_s3;
	logic              sign_s3, nan_s3, inf_s3, zero_s3;

	logic [31:0] res_s4;

	// unpack and normalize subnormal inputs
	always_comb begin
		ea = (a[30:23] == 8'd0) ? 8'd1 : a[30:23];
		eb = (b[30:23] == 8'd0) ? 8'd1 : b[30:23];
		ma0 = {a[30:23] != 8'd0, a[22:0]};
		mb0 = {b[30:23] != 8'd0, b[22:0]};
		lza = rbs_pkg::lzc48({ma0, 24'd0});
		lzb = rbs_pkg::lzc48({mb0, 24'd0});
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ma_s1   <= ma0 << lza;
			mb_s1   <= mb0 << lzb;
			na_s1   <= 10'({2'b00, ea}) - 10'({4'd0, lza});
			nb_s1   <= 10'({2'b00, eb}) - 10'({4'd0, lzb});
			sign_s1 <= a[31] ^ b[31];
			nan_s1  <= rbs_pkg::is_nan(a) | rbs_pkg::is_nan(b)
				| (rbs_pkg::is_inf(a) & rbs_pkg::is_zero(b))
				| (rbs_pkg::is_zero(a) & rbs_pkg::is_inf(b));
			inf_s1  <= rbs_pkg::is_inf(a) | rbs_pkg::is_inf(b);
			zero_s1 <= rbs_pkg::is_zero(a) | rbs_pkg::is_zero(b);
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			prod_s2 <= ma_s1 * mb_s1;
			exp_s2  <= na_s1 + nb_s1 - 10'sd127;
			sign_s2 <= sign_s1;
			nan_s2  <= nan_s1;
			inf_s2  <= inf_s1;
			zero_s2 <= zero_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			if (prod_s2[47]) begin
				mant_s3 <= {prod_s2[47:22], |prod_s2[21:0]};
				exp_s3  <= exp_s2 + 10'sd1;
			end else begin
				mant_s3 <= {prod_s2[46:21], |prod_s2[20:0]};
				exp_s3  <= exp_s2;
			end
			sign_s3 <= sign_s2;
			nan_s3  <= nan_s2;
			inf_s3  <= inf_s2;
			zero_s3 <= zero_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			if (nan_s3) begin
				res_s4 <= rbs_pkg::F_QNAN;
			end else if (inf_s3) begin
				res_s4 <= {sign_s3, rbs_pkg::F_POS_INF[30:0]};
			end else if (zero_s3) begin
				res_s4 <= {sign_s3, 31'd0};
			end else begin
				res_s4 <= rbs_pkg::round_pack(sign_s3, exp_s3, mant_s3);
			end
		end
	end

	assign res = res_s4;

endmodule

// File: rtl/rbs_recip.sv
// pipelined reciprocal, one quotient bit per stage
module rbs_recip (
	input  logic        clk,
	input  logic        en,
	input  logic [31:0] d,
	output logic [31:0] res
);

	typedef struct packed {
		logic              sign;
		logic              nan;
		logic              inf;
		logic              zero;
		logic signed [9:0] exp;
	} rcp_meta_t;

	localparam int N = rbs_pkg::DIV_STEPS;

	logic [7:0]  e_eff;
	logic [23:0] m0;
	logic [5:0]  lz;
	rcp_meta_t   meta_in;

	rcp_meta_t   meta_s [0:N];
	logic [24:0] rem_s  [0:N];
	logic [27:0] quo_s  [0:N];
	logic [23:0] div_s  [0:N];

	logic [27:0]       q;
	logic              st;
	logic [26:0]       mant_f;
	logic signed [9:0] exp_f;
	logic [31:0]       res_q;

	always_comb begin
		e_eff = (d[30:23] == 8'd0) ? 8'd1 : d[30:23];
		m0 = {d[30:23] != 8'd0, d[22:0]};
		lz = rbs_pkg::lzc48({m0, 24'd0});
		meta_in.sign = d[31];
		meta_in.nan = rbs_pkg::is_nan(d);
		meta_in.inf = rbs_pkg::is_inf(d);
		meta_in.zero = rbs_pkg::is_zero(d);
		meta_in.exp = 10'sd253 - (10'({2'b00, e_eff}) - 10'({4'd0, lz}));
	end

	always_ff @(posedge clk) begin
		if (en) begin
			meta_s[0] <= meta_in;
			rem_s[0]  <= 25'h080_0000;
			quo_s[0]  <= '0;
			div_s[0]  <= m0 << lz;
		end
	end

	for (genvar k = 1; k <= N; k++) begin : g_step
		always_ff @(posedge clk) begin
			if (en) begin
				meta_s[k] <= meta_s[k-1];
				div_s[k]  <= div_s[k-1];
				if (rem_s[k-1] >= {1'b0, div_s[k-1]}) begin
					rem_s[k] <= 25'((rem_s[k-1] - {1'b0, div_s[k-1]}) << 1);
					quo_s[k] <= {quo_s[k-1][26:0], 1'b1};
				end else begin
					rem_s[k] <= 25'(rem_s[k-1] << 1);
					quo_s[k] <= {quo_s[k-1][26:0], 1'b0};
				end
			end
		end
	end

	// quotient is one exactly for a power-of-two divisor
	always_comb begin
		q = quo_s[N];
		st = rem_s[N] != 25'd0;
		if (q[27]) begin
			mant_f = {q[27:2], q[1] | q[0] | st};
			exp_f = meta_s[N].exp + 10'sd1;
		end else begin
			mant_f = {q[26:1], q[0] | st};
			exp_f = meta_s[N].exp;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			if (meta_s[N].nan) begin
				res_q <= rbs_pkg::F_QNAN;
			end else if (meta_s[N].inf) begin
				res_q <= {meta_s[N].sign, 31'd0};
			end else if (meta_s[N].zero) begin
				res_q <= {meta_s[N].sign, rbs_pkg::F_POS_INF[30:0]};
			end else begin
				res_q <= rbs_pkg::round_pack(meta_s[N].sign, exp_f, mant_f);
			end
		end
	end

	assign res = res_q;

endmodule

// File: rtl/rbs_lane.sv
// one axis: reciprocal, slab offsets, slab distances, ordered pair
module rbs_lane (
	input  logic        clk,
	input  logic        en,
	input  logic [31:0] origin,
	input  logic [31:0] dir,
	input  logic [31:0] box_min,
	input  logic [31:0] box_max,
	output logic [31:0] t0,
	output logic [31:0] t1
);

	localparam int DLY = rbs_pkg::SUB_DLY;
	localparam int MLY = rbs_pkg::FMUL_LAT;

	logic [31:0] inv, d0, d1, m0, m1;
	logic [31:0] d0_s [0:DLY-1];
	logic [31:0] d1_s [0:DLY-1];
	logic        swp;
	logic        swp_s [0:MLY-1];

	rbs_recip u_recip (.clk(clk), .en(en), .d(dir), .res(inv));
	rbs_fsub u_sub0 (.clk(clk), .en(en), .a(box_min), .b(origin), .res(d0));
	rbs_fsub u_sub1 (.clk(clk), .en(en), .a(box_max), .b(origin), .res(d1));

	// line the offsets up with the reciprocal
	always_ff @(posedge clk) begin
		if (en) begin
			d0_s[0] <= d0;
			d1_s[0] <= d1;
		end
	end

	for (genvar k = 1; k < DLY; k++) begin : g_dly
		always_ff @(posedge clk) begin
			if (en) begin
				d0_s[k] <= d0_s[k-1];
				d1_s[k] <= d1_s[k-1];
			end
		end
	end

	rbs_fmul u_mul0 (.clk(clk), .en(en), .a(d0_s[DLY-1]), .b(inv), .res(m0));
	rbs_fmul u_mul1 (.clk(clk), .en(en), .a(d1_s[DLY-1]), .b(inv), .res(m1));

	// strictly negative reciprocal swaps the pair
	assign swp = inv[31] & ~rbs_pkg::is_nan(inv) & ~rbs_pkg::is_zero(inv);

	always_ff @(posedge clk) begin
		if (en) begin
			swp_s[0] <= swp;
		end
	end

	for (genvar k = 1; k < MLY; k++) begin : g_swp
		always_ff @(posedge clk) begin
			if (en) begin
				swp_s[k] <= swp_s[k-1];
			end
		end
	end

	assign t0 = swp_s[MLY-1] ? m1 : m0;
	assign t1 = swp_s[MLY-1] ? m0 : m1;

endmodule

// File: rtl/rbs_merge.sv
// folds the per-axis distances into entry and exit distances
module rbs_merge (
	input  logic        clk,
	input  logic        en,
	input  logic [31:0] t0 [0:rbs_pkg::AXES-1],
	input  logic [31:0] t1 [0:rbs_pkg::AXES-1],
	output logic [31:0] near,
	output logic [31:0] far
);

	localparam int LAST = rbs_pkg::AXES - 1;

	logic [31:0] n_c, f_c;
	logic [31:0] near_s1, far_s1, t0_s1, t1_s1;
	logic [31:0] near_s2, far_s2;

	// nan never wins a compare, so it never narrows the interval
	always_comb begin
		n_c = rbs_pkg::F_NEG_INF;
		f_c = rbs_pkg::F_POS_INF;
		for (int a = 0; a < LAST; a++) begin
			if (rbs_pkg::f_lt(n_c, t0[a])) begin
				n_c = t0[a];
			end
			if (rbs_pkg::f_lt(t1[a], f_c)) begin
				f_c = t1[a];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			near_s1 <= n_c;
			far_s1  <= f_c;
			t0_s1   <= t0[LAST];
			t1_s1   <= t1[LAST];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			near_s2 <= rbs_pkg::f_lt(near_s1, t0_s1) ? t0_s1 : near_s1;
			far_s2  <= rbs_pkg::f_lt(t1_s1, far_s1) ? t1_s1 : far_s1;
		end
	end

	assign near = near_s2;
	assign far  = far_s2;

endmodule
